// File: design/utf8_decode_accent_fold_assert.svh
// Assertion macros for the UTF-8 decoder with accent folding.
// Included by the modules that check their own logic; no other dependencies.
`ifndef UTF8_DECODE_ACCENT_FOLD_ASSERT_SVH
`define UTF8_DECODE_ACCENT_FOLD_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define UDAF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("udaf assertion failed");
// Expression must never be true outside reset.
`define UDAF_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("udaf forbidden condition seen");
`else
`define UDAF_ASSERT(lbl, clk, rstn, prop)
`define UDAF_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// File: design/udaf_pkg.sv
// Shared types, constants and folding functions for the UTF-8 decoder.
// No dependencies; imported by every module of the block.
package udaf_pkg;

    // Code-point counter width, capped so the count fits the 16-bit port
    localparam int COUNT_BITS = 16;
    localparam int CNT_W      = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    // Job queue between the front and back ends
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Byte classes
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] NUL_BYTE  = 8'h00;

    // Special code points
    localparam logic [15:0] RIGHT_QUOTE = 16'h2019;
    localparam logic [15:0] APOSTROPHE  = 16'h0027;

    // Accent classes
    localparam logic [2:0] ACC_NONE       = 3'd0;
    localparam logic [2:0] ACC_ACUTE      = 3'd1;
    localparam logic [2:0] ACC_GRAVE      = 3'd2;
    localparam logic [2:0] ACC_CIRCUMFLEX = 3'd3;
    localparam logic [2:0] ACC_DIAERESIS  = 3'd4;
    localparam logic [2:0] ACC_CEDILLA    = 3'd5;

    // One result to produce: a code point, or the terminator
    typedef struct packed {
        logic [15:0] cp;
        logic        term;
    } slot_t;

    // All results caused by one input byte (num is 1..3)
    typedef struct packed {
        logic [1:0]  num;
        slot_t [2:0] slots;
    } job_t;

    // Front to queue push
    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // Uppercase, accent-stripped base letter
    function automatic logic [15:0] fold_base(input logic [15:0] c);
        logic [15:0] r;
        r = c;
        if (c >= 16'h0061 && c <= 16'h007A) begin
            r = c - 16'd32;
        end else begin
            case (c)
                16'h00C0, 16'h00E0, 16'h00C2, 16'h00E2: r = 16'h0041;
                16'h00C7, 16'h00E7: r = 16'h0043;
                16'h00C8, 16'h00E8, 16'h00C9, 16'h00E9,
                16'h00CA, 16'h00EA, 16'h00CB, 16'h00EB: r = 16'h0045;
                16'h00CE, 16'h00EE, 16'h00CF, 16'h00EF: r = 16'h0049;
                16'h00D4, 16'h00F4: r = 16'h004F;
                16'h00D9, 16'h00F9, 16'h00DB, 16'h00FB,
                16'h00DC, 16'h00FC: r = 16'h0055;
                RIGHT_QUOTE: r = APOSTROPHE;
                default: r = c;
            endcase
        end
        return r;
    endfunction

    // French accent class of a code point
    function automatic logic [2:0] fold_accent(input logic [15:0] c);
        logic [2:0] r;
        case (c)
            16'h00C9, 16'h00E9: r = ACC_ACUTE;
            16'h00C0, 16'h00E0, 16'h00C8, 16'h00E8,
            16'h00D9, 16'h00F9: r = ACC_GRAVE;
            16'h00C2, 16'h00E2, 16'h00CA, 16'h00EA, 16'h00CE, 16'h00EE,
            16'h00D4, 16'h00F4, 16'h00DB, 16'h00FB: r = ACC_CIRCUMFLEX;
            16'h00CB, 16'h00EB, 16'h00CF, 16'h00EF,
            16'h00DC, 16'h00FC: r = ACC_DIAERESIS;
            16'h00C7, 16'h00E7: r = ACC_CEDILLA;
            default: r = ACC_NONE;
        endcase
        return r;
    endfunction

endpackage

// File: design/udaf_front.sv
// Front end: accepts bytes, tracks the pending UTF-8 sequence and turns each
// byte into a job of up to three results. Depends on udaf_pkg.
module udaf_front
    import udaf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       q_full,
    output push_t      push
);

    logic [7:0] lead_reg, lead_next;
    logic [7:0] cont_reg, cont_next;
    logic [1:0] pcnt_reg, pcnt_next;

    logic       accept;
    logic       fr_emit;
    logic       fr_hold;
    slot_t      fr_slot;
    slot_t      lead_slot;
    slot_t      cont_slot;
    job_t       job;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Byte handled with nothing held
    always_comb begin
        fr_slot.cp   = {8'h00, s_byte_in};
        fr_slot.term = (s_byte_in == NUL_BYTE);
        fr_hold      = (s_byte_in >= LEAD2_MIN) && (s_byte_in <= LEAD3_MAX);
        fr_emit      = !fr_hold;
    end

    assign lead_slot = '{cp: {8'h00, lead_reg}, term: 1'b0};
    assign cont_slot = '{cp: {8'h00, cont_reg}, term: 1'b0};

    // Sequence tracking and job build
    always_comb begin
        lead_next = lead_reg;
        cont_next = cont_reg;
        pcnt_next = pcnt_reg;
        job       = '0;
        case (pcnt_reg)
            2'd1: begin
                if (is_cont(s_byte_in) && lead_reg < LEAD3_MIN) begin
                    job.num            = 2'd1;
                    job.slots[0].cp    = {5'd0, lead_reg[4:0], s_byte_in[5:0]};
                    pcnt_next          = 2'd0;
                end else if (is_cont(s_byte_in)) begin
                    cont_next          = s_byte_in;
                    pcnt_next          = 2'd2;
                end else begin
                    job.num      = fr_emit ? 2'd2 : 2'd1;
                    job.slots[0] = lead_slot;
                    job.slots[1] = fr_slot;
                    pcnt_next    = fr_hold ? 2'd1 : 2'd0;
                    lead_next    = fr_hold ? s_byte_in : lead_reg;
                end
            end
            2'd2: begin
                if (is_cont(s_byte_in)) begin
                    job.num         = 2'd1;
                    job.slots[0].cp = {lead_reg[3:0], cont_reg[5:0], s_byte_in[5:0]};
                    pcnt_next       = 2'd0;
                end else begin
                    job.num      = fr_emit ? 2'd3 : 2'd2;
                    job.slots[0] = lead_slot;
                    job.slots[1] = cont_slot;
                    job.slots[2] = fr_slot;
                    pcnt_next    = fr_hold ? 2'd1 : 2'd0;
                    lead_next    = fr_hold ? s_byte_in : lead_reg;
                end
            end
            default: begin
                job.num      = fr_emit ? 2'd1 : 2'd0;
                job.slots[0] = fr_slot;
                pcnt_next    = fr_hold ? 2'd1 : 2'd0;
                lead_next    = fr_hold ? s_byte_in : lead_reg;
            end
        endcase
    end

    assign push.valid = accept && (job.num != 2'd0);
    assign push.job   = job;

    // Pending sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg <= '0;
            cont_reg <= '0;
            pcnt_reg <= '0;
        end else if (accept) begin
            lead_reg <= lead_next;
            cont_reg <= cont_next;
            pcnt_reg <= pcnt_next;
        end
    end

endmodule

// File: design/udaf_queue.sv
// Short job queue that decouples the front and back ends.
// Depends on udaf_pkg and the assertion macro header.
`include "utf8_decode_accent_fold_assert.svh"
module udaf_queue
    import udaf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  full,
    output logic  head_valid,
    output job_t  head_job,
    input  logic  pop
);

    job_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push.valid) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)        rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push.valid, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    `UDAF_NEVER(q_no_overflow, aclk, aresetn, push.valid && full)
    `UDAF_NEVER(q_no_underflow, aclk, aresetn, pop && !head_valid)
    `UDAF_ASSERT(q_head_nonempty_job, aclk, aresetn, head_valid |-> head_job.num != 2'd0)

endmodule

// File: design/udaf_back.sv
// Back end: emits job results one per cycle unless stalled, folds accents,
// keeps the code-point count. Depends on udaf_pkg and the assertion header.
`include "utf8_decode_accent_fold_assert.svh"
module udaf_back
    import udaf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  job_t        head_job,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_point,
    output logic [15:0] m_base_char,
    output logic [2:0]  m_accent_class,
    output logic        m_is_terminator,
    output logic [15:0] m_char_count,
    output logic        m_last_result
);

    logic [1:0]       idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             valid_reg;
    logic [15:0]      cp_reg;
    logic [15:0]      base_reg;
    logic [2:0]       acc_reg;
    logic             term_reg;
    logic [15:0]      ccnt_reg;
    logic             last_reg;

    logic  load;
    logic  is_last;
    slot_t cur;

    assign load    = head_valid && (!valid_reg || m_ready);
    assign cur     = head_job.slots[idx_reg];
    assign is_last = (idx_reg == head_job.num - 2'd1);
    assign pop     = load && is_last;

    // Slot index and running count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
                if (cur.term) begin
                    count_reg <= '0;
                end else if (count_reg != '1) begin
                    count_reg <= count_reg + 1'b1;
                end
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg   <= cur.cp;
            base_reg <= fold_base(cur.cp);
            acc_reg  <= fold_accent(cur.cp);
            term_reg <= cur.term;
            ccnt_reg <= cur.term ? 16'(count_reg) : 16'd0;
            last_reg <= is_last;
        end
    end

    assign m_valid         = valid_reg;
    assign m_code_point    = cp_reg;
    assign m_base_char     = base_reg;
    assign m_accent_class  = acc_reg;
    assign m_is_terminator = term_reg;
    assign m_char_count    = ccnt_reg;
    assign m_last_result   = last_reg;

    `UDAF_ASSERT(b_term_is_last, aclk, aresetn, m_valid && m_is_terminator |-> m_last_result)
    `UDAF_ASSERT(b_count_only_on_term, aclk, aresetn, m_valid && !m_is_terminator |-> m_char_count == 16'd0)
    `UDAF_ASSERT(b_count_cleared_after_term, aclk, aresetn, load && cur.term |=> count_reg == '0)

endmodule

// File: design/utf8_decode_accent_fold.sv
// Streaming UTF-8 decoder (one to three byte sequences) with French accent
// folding. One byte is accepted per cycle while the four-entry job queue
// between the front end and the result stage has room; the result stage
// delivers one result per cycle while m_ready does not stall it, and a byte
// releases at most three results. A result passes through the job queue and
// then the output register of the result stage before it is valid on m_.
// A zero byte flushes any held bytes and yields a terminator carrying the
// saturating code-point count.
// Depends on udaf_pkg, udaf_front, udaf_queue and udaf_back.
module utf8_decode_accent_fold
    import udaf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_point,
    output logic [15:0] m_base_char,
    output logic [2:0]  m_accent_class,
    output logic        m_is_terminator,
    output logic [15:0] m_char_count,
    output logic        m_last_result
);

    push_t push;
    logic  q_full;
    logic  head_valid;
    job_t  head_job;
    logic  pop;

    udaf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .q_full    (q_full),
        .push      (push)
    );

    udaf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    udaf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_job        (head_job),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_base_char     (m_base_char),
        .m_accent_class  (m_accent_class),
        .m_is_terminator (m_is_terminator),
        .m_char_count    (m_char_count),
        .m_last_result   (m_last_result)
    );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for utf8_decode_accent_fold: directed bytes and random
// UTF-8 words under varying backpressure.
// Depends on udaf_pkg and the utf8_decode_accent_fold RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import udaf_pkg::*;

    localparam int CYCLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS_PER_PHASE = 40;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [15:0] COUNT_MAX = 16'((64'd1 << CNT_W) - 1);

    // One result as seen on the m_ channel
    typedef struct packed {
        logic [15:0] cp;
        logic [15:0] base;
        logic [2:0]  acc;
        logic        term;
        logic [15:0] cnt;
        logic        last;
    } decoded_t;

    // Directed stimulus row: a byte and, where obvious, its single result
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        decoded_t   want;
    } byte_row_t;

    localparam decoded_t NO_RESULT = '0;
    localparam int NUM_ROWS = 25;
    localparam byte_row_t BYTE_ROWS [0:NUM_ROWS-1] = '{
        '{8'h00, 1'b1, '{16'h0000, 16'h0000, ACC_NONE, 1'b1, 16'd0, 1'b1}},
        '{8'h61, 1'b1, '{16'h0061, 16'h0041, ACC_NONE, 1'b0, 16'd0, 1'b1}},
        '{8'h80, 1'b1, '{16'h0080, 16'h0080, ACC_NONE, 1'b0, 16'd0, 1'b1}},
        '{8'hFF, 1'b1, '{16'h00FF, 16'h00FF, ACC_NONE, 1'b0, 16'd0, 1'b1}},
        '{8'hC0, 1'b1, '{16'h00C0, 16'h0041, ACC_GRAVE, 1'b0, 16'd0, 1'b1}},
        // e acute, then right single quote
        '{8'hC3, 1'b0, NO_RESULT},
        '{8'hA9, 1'b0, NO_RESULT},
        '{8'hE2, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h99, 1'b0, NO_RESULT},
        // two-byte lead broken by ASCII
        '{8'hC3, 1'b0, NO_RESULT},
        '{8'h41, 1'b0, NO_RESULT},
        // three-byte sequence broken after one continuation
        '{8'hE0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h42, 1'b0, NO_RESULT},
        // held lead flushed by the terminator
        '{8'hE9, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        // largest two- and three-byte code points
        '{8'hDF, 1'b0, NO_RESULT},
        '{8'hBF, 1'b0, NO_RESULT},
        '{8'hEF, 1'b0, NO_RESULT},
        '{8'hBF, 1'b0, NO_RESULT},
        '{8'hBF, 1'b0, NO_RESULT},
        // two held bytes flushed by the terminator: three results
        '{8'hED, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_code_point;
    logic [15:0] m_base_char;
    logic [2:0]  m_accent_class;
    logic        m_is_terminator;
    logic [15:0] m_char_count;
    logic        m_last_result;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    // Decoder state mirror
    logic [7:0]  held_lead = 8'h00;
    logic [7:0]  held_cont = 8'h00;
    logic [1:0]  held_num = 2'd0;
    logic [15:0] cp_count = 16'd0;

    decoded_t step_results[$];
    decoded_t expected_results[$];

    utf8_decode_accent_fold DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_base_char     (m_base_char),
        .m_accent_class  (m_accent_class),
        .m_is_terminator (m_is_terminator),
        .m_char_count    (m_char_count),
        .m_last_result   (m_last_result)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Uppercase letter with the accent removed
    function automatic logic [15:0] plain_letter(input logic [15:0] c);
        if (c >= 16'h0061 && c <= 16'h007A) begin
            return c - 16'd32;
        end
        case (c)
            16'h00C0, 16'h00C2, 16'h00E0, 16'h00E2: return 16'h0041;
            16'h00C7, 16'h00E7: return 16'h0043;
            16'h00C8, 16'h00C9, 16'h00CA, 16'h00CB,
            16'h00E8, 16'h00E9, 16'h00EA, 16'h00EB: return 16'h0045;
            16'h00CE, 16'h00CF, 16'h00EE, 16'h00EF: return 16'h0049;
            16'h00D4, 16'h00F4: return 16'h004F;
            16'h00D9, 16'h00DB, 16'h00DC,
            16'h00F9, 16'h00FB, 16'h00FC: return 16'h0055;
            RIGHT_QUOTE: return APOSTROPHE;
            default: return c;
        endcase
    endfunction

    function automatic logic [2:0] accent_of(input logic [15:0] c);
        case (c)
            16'h00C9, 16'h00E9: return ACC_ACUTE;
            16'h00C0, 16'h00C8, 16'h00D9,
            16'h00E0, 16'h00E8, 16'h00F9: return ACC_GRAVE;
            16'h00C2, 16'h00CA, 16'h00CE, 16'h00D4, 16'h00DB,
            16'h00E2, 16'h00EA, 16'h00EE, 16'h00F4, 16'h00FB: return ACC_CIRCUMFLEX;
            16'h00CB, 16'h00CF, 16'h00DC,
            16'h00EB, 16'h00EF, 16'h00FC: return ACC_DIAERESIS;
            16'h00C7, 16'h00E7: return ACC_CEDILLA;
            default: return ACC_NONE;
        endcase
    endfunction

    function automatic logic is_continuation(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    task automatic emit_code(input logic [15:0] cp);
        step_results.push_back('{cp, plain_letter(cp), accent_of(cp), 1'b0, 16'd0, 1'b0});
        if (cp_count < COUNT_MAX) begin
            cp_count++;
        end
    endtask

    // Byte seen with nothing held
    task automatic start_fresh(input logic [7:0] b);
        held_num = 2'd0;
        if (b == NUL_BYTE) begin
            step_results.push_back('{16'h0000, 16'h0000, ACC_NONE, 1'b1, cp_count, 1'b0});
            cp_count = 16'd0;
        end else if (b >= LEAD2_MIN && b <= LEAD3_MAX) begin
            held_lead = b;
            held_num = 2'd1;
        end else begin
            emit_code({8'h00, b});
        end
    endtask

    // Results that one accepted byte releases, into step_results
    task automatic decode_byte(input logic [7:0] b);
        step_results.delete();
        case (held_num)
            2'd1: begin
                if (is_continuation(b)) begin
                    if (held_lead < LEAD3_MIN) begin
                        held_num = 2'd0;
                        emit_code({5'b0, held_lead[4:0], b[5:0]});
                    end else begin
                        held_cont = b;
                        held_num = 2'd2;
                    end
                end else begin
                    emit_code({8'h00, held_lead});
                    start_fresh(b);
                end
            end
            2'd2: begin
                if (is_continuation(b)) begin
                    held_num = 2'd0;
                    emit_code({held_lead[3:0], held_cont[5:0], b[5:0]});
                end else begin
                    emit_code({8'h00, held_lead});
                    emit_code({8'h00, held_cont});
                    start_fresh(b);
                end
            end
            default: start_fresh(b);
        endcase
    endtask

    // Offer one byte, wait for acceptance, then queue what it should produce
    task automatic send_byte(input logic [7:0] b, input logic typed, input decoded_t want);
        decoded_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_in <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        decode_byte(b);
        if (typed) begin
            expected_results.push_back(want);
        end else begin
            for (int i = 0; i < step_results.size(); i++) begin
                r = step_results[i];
                r.last = (i == step_results.size() - 1);
                expected_results.push_back(r);
            end
        end
    endtask

    function automatic logic [7:0] random_cont();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // One random word: mostly well-formed UTF-8, some noise and broken sequences
    task automatic send_word(inout int sent);
        int kind;
        logic [7:0] lead;
        logic [7:0] breaker;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0, NO_RESULT);
            sent += 1;
        end else if (kind < 45) begin
            // French accented letters live at C3 80..BF
            send_byte(8'hC3, 1'b0, NO_RESULT);
            send_byte(random_cont(), 1'b0, NO_RESULT);
            sent += 2;
        end else if (kind < 55) begin
            send_byte(8'($urandom_range(LEAD2_MIN, 8'hDF)), 1'b0, NO_RESULT);
            send_byte(random_cont(), 1'b0, NO_RESULT);
            sent += 2;
        end else if (kind < 65) begin
            send_byte(8'($urandom_range(LEAD3_MIN, LEAD3_MAX)), 1'b0, NO_RESULT);
            send_byte(random_cont(), 1'b0, NO_RESULT);
            send_byte(random_cont(), 1'b0, NO_RESULT);
            sent += 3;
        end else if (kind < 70) begin
            send_byte(8'hE2, 1'b0, NO_RESULT);
            send_byte(8'h80, 1'b0, NO_RESULT);
            send_byte(8'h99, 1'b0, NO_RESULT);
            sent += 3;
        end else if (kind < 78) begin
            send_byte(NUL_BYTE, 1'b0, NO_RESULT);
            sent += 1;
        end else if (kind < 88) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            sent += 1;
        end else begin
            // lead, maybe one continuation, then a byte that is not a continuation
            lead = 8'($urandom_range(LEAD2_MIN, LEAD3_MAX));
            send_byte(lead, 1'b0, NO_RESULT);
            sent += 1;
            if (lead >= LEAD3_MIN && $urandom_range(0, 1)) begin
                send_byte(random_cont(), 1'b0, NO_RESULT);
                sent += 1;
            end
            breaker = 8'($urandom_range(0, 255));
            if (is_continuation(breaker)) begin
                breaker = breaker ^ 8'h40;
            end
            send_byte(breaker, 1'b0, NO_RESULT);
            sent += 1;
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int sent;
        sent = 0;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < RANDOM_ITEMS_PER_PHASE) begin
            send_word(sent);
        end
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic compare_field(input string label, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
            error_count++;
        end
    endtask

    // Result checker and receiver backpressure
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got cp %h term %b",
                         $time, m_code_point, m_is_terminator);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("code_point", want.cp, m_code_point);
                compare_field("base_char", want.base, m_base_char);
                compare_field("accent_class", 16'(want.acc), 16'(m_accent_class));
                compare_field("is_terminator", 16'(want.term), 16'(m_is_terminator));
                compare_field("char_count", want.cnt, m_char_count);
                compare_field("last_result", 16'(want.last), 16'(m_last_result));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed bytes, no idling
        for (int i = 0; i < NUM_ROWS; i++) begin
            send_byte(BYTE_ROWS[i].b, BYTE_ROWS[i].typed, BYTE_ROWS[i].want);
        end

        run_random_phase(0, 0);
        run_random_phase(48, 0);
        // Let the block run dry before carrying on
        wait_all_results();
        run_random_phase(0, 48);
        run_random_phase(32, 32);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
